### design/brz_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brz_pkg
// Shared widths, register indexes and types of the bilinear resize
// coordinate generator.
// ----------------------------------------------------------------------------
package brz_pkg;

  localparam int MAX_SIZE     = 4096;
  localparam int MAX_CHANNELS = 4;

  localparam int INDEX_W  = 12;
  localparam int SIZE_W   = 13;
  localparam int CHAN_W   = 3;
  localparam int SCALE_W  = 17;
  localparam int OFFSET_W = 14;
  localparam int WEIGHT_W = 17;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam int DVD_W = 29;
  localparam int REM_W = SIZE_W;
  localparam int FRAC_W = INDEX_W;

  localparam logic [1:0] REG_SRC_SIZE     = 2'd0;
  localparam logic [1:0] REG_DST_SIZE     = 2'd1;
  localparam logic [1:0] REG_CHANNELS     = 2'd2;
  localparam logic [1:0] REG_WEIGHT_SCALE = 2'd3;

  typedef struct packed {
    logic [SIZE_W-1:0]  src;
    logic [SIZE_W-1:0]  dst;
    logic [CHAN_W-1:0]  cn;
    logic [SCALE_W-1:0] ws;
  } cfg_t;

  typedef struct packed {
    logic              err;
    logic              zero_w;
    logic [SIZE_W-1:0] ix;
  } side_t;

endpackage

`default_nettype wire

### design/brz_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brz_in_if / brz_out_if
// Valid/ready channels for destination indexes and coordinate results.
// ----------------------------------------------------------------------------
interface brz_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] dst_index;

  modport source (output valid, output dst_index, input ready);
  modport sink (input valid, input dst_index, output ready);
endinterface

interface brz_out_if;
  logic        valid;
  logic        ready;
  logic [13:0] src_offset;
  logic [16:0] weight;
  logic        index_error;

  modport source (output valid, output src_offset, output weight, output index_error,
                  input ready);
  modport sink (input valid, input src_offset, input weight, input index_error,
                output ready);
endinterface

`default_nettype wire

### design/brz_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brz_cfg
// APB-style register file with clamped working values of the size and channel registers.
// ----------------------------------------------------------------------------
module brz_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [brz_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [brz_pkg::DATA_W-1:0]  pwdata,
  output logic      [brz_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  output brz_pkg::cfg_t                    cfg
);
  import brz_pkg::*;

  logic [SIZE_W-1:0]  src_size_r;
  logic [SIZE_W-1:0]  dst_size_r;
  logic [CHAN_W-1:0]  channels_r;
  logic [SCALE_W-1:0] weight_scale_r;
  logic               wr_en;
  logic [1:0]         reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_size_r     <= SIZE_W'(2);
      dst_size_r     <= SIZE_W'(1);
      channels_r     <= CHAN_W'(1);
      weight_scale_r <= SCALE_W'(256);
    end else if (wr_en) begin
      case (reg_idx)
        REG_SRC_SIZE:     src_size_r     <= pwdata[SIZE_W-1:0];
        REG_DST_SIZE:     dst_size_r     <= pwdata[SIZE_W-1:0];
        REG_CHANNELS:     channels_r     <= pwdata[CHAN_W-1:0];
        REG_WEIGHT_SCALE: weight_scale_r <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SRC_SIZE:     prdata = DATA_W'(src_size_r);
      REG_DST_SIZE:     prdata = DATA_W'(dst_size_r);
      REG_CHANNELS:     prdata = DATA_W'(channels_r);
      REG_WEIGHT_SCALE: prdata = DATA_W'(weight_scale_r);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    if (src_size_r > SIZE_W'(MAX_SIZE)) begin
      cfg.src = SIZE_W'(MAX_SIZE);
    end else if (src_size_r < SIZE_W'(2)) begin
      cfg.src = SIZE_W'(2);
    end else begin
      cfg.src = src_size_r;
    end
    cfg.dst = (dst_size_r > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : dst_size_r;
    cfg.cn  = (channels_r > CHAN_W'(MAX_CHANNELS)) ? CHAN_W'(MAX_CHANNELS) : channels_r;
    cfg.ws  = weight_scale_r;
  end

endmodule

`default_nettype wire

### design/brz_prep.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brz_prep
// First stage: range check of the index and the product index * src_size.
// ----------------------------------------------------------------------------
module brz_prep (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic [brz_pkg::INDEX_W-1:0] in_index,
  input  wire brz_pkg::cfg_t               cfg,
  output logic                             out_valid,
  output logic      [brz_pkg::DVD_W-1:0]   out_pos,
  output brz_pkg::side_t                   out_side
);
  import brz_pkg::*;

  logic                       vld_r;
  logic [DVD_W-1:0]           pos_r;
  logic                       err_r;
  logic [INDEX_W+SIZE_W-1:0]  pos_nxt;
  logic                       err_nxt;

  assign pos_nxt = (INDEX_W+SIZE_W)'(in_index) * (INDEX_W+SIZE_W)'(cfg.src);
  assign err_nxt = SIZE_W'(in_index) >= cfg.dst;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos_r <= DVD_W'(pos_nxt);
      err_r <= err_nxt;
    end
  end

  assign out_valid       = vld_r;
  assign out_pos         = pos_r;
  assign out_side.err    = err_r;
  assign out_side.zero_w = 1'b0;
  assign out_side.ix     = '0;

endmodule

`default_nettype wire

### design/brz_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brz_div
// Pipelined restoring divider, one quotient bit per stage, with side data
// carried alongside each item.
// ----------------------------------------------------------------------------
module brz_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       in_valid,
  input  wire logic [brz_pkg::DVD_W-1:0]  in_dvd,
  input  wire logic [brz_pkg::SIZE_W-1:0] in_dvs,
  input  wire brz_pkg::side_t             in_side,
  output logic                            out_valid,
  output logic      [brz_pkg::DVD_W-1:0]  out_quot,
  output logic      [brz_pkg::REM_W-1:0]  out_rem,
  output brz_pkg::side_t                  out_side
);
  import brz_pkg::*;

  logic               vld_r  [DVD_W];
  logic [REM_W-1:0]   rem_r  [DVD_W];
  logic [DVD_W-1:0]   dq_r   [DVD_W];
  side_t              side_r [DVD_W];

  logic               src_vld  [DVD_W];
  logic [REM_W-1:0]   src_rem  [DVD_W];
  logic [DVD_W-1:0]   src_dq   [DVD_W];
  side_t              src_side [DVD_W];

  logic [REM_W-1:0]   rem_nxt  [DVD_W];
  logic [DVD_W-1:0]   dq_nxt   [DVD_W];

  assign src_vld[0]  = in_valid;
  assign src_rem[0]  = '0;
  assign src_dq[0]   = in_dvd;
  assign src_side[0] = in_side;

  for (genvar g = 0; g < DVD_W; g++) begin : g_stage
    logic [REM_W:0] part;
    logic [REM_W:0] diff;
    logic           ge;

    if (g > 0) begin : g_link
      assign src_vld[g]  = vld_r[g-1];
      assign src_rem[g]  = rem_r[g-1];
      assign src_dq[g]   = dq_r[g-1];
      assign src_side[g] = side_r[g-1];
    end

    assign part       = {src_rem[g], src_dq[g][DVD_W-1]};
    assign ge         = part >= {1'b0, in_dvs};
    assign diff       = part - {1'b0, in_dvs};
    assign rem_nxt[g] = ge ? diff[REM_W-1:0] : part[REM_W-1:0];
    assign dq_nxt[g]  = {src_dq[g][DVD_W-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= src_vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= rem_nxt[g];
        dq_r[g]   <= dq_nxt[g];
        side_r[g] <= src_side[g];
      end
    end
  end

  assign out_valid = vld_r[DVD_W-1];
  assign out_quot  = dq_r[DVD_W-1];
  assign out_rem   = rem_r[DVD_W-1];
  assign out_side  = side_r[DVD_W-1];

endmodule

`default_nettype wire

### design/brz_wprep.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brz_wprep
// Snaps the fraction to zero or one where it is close, moves the left pixel
// on when it snaps to one, and forms remainder * weight_scale.
// ----------------------------------------------------------------------------
module brz_wprep (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       in_valid,
  input  wire logic [brz_pkg::DVD_W-1:0]  in_quot,
  input  wire logic [brz_pkg::REM_W-1:0]  in_rem,
  input  wire brz_pkg::side_t             in_side,
  input  wire brz_pkg::cfg_t              cfg,
  output logic                            out_valid,
  output logic      [brz_pkg::DVD_W-1:0]  out_prod,
  output brz_pkg::side_t                  out_side
);
  import brz_pkg::*;

  logic                      vld_r;
  logic [DVD_W-1:0]          prod_r;
  side_t                     side_r;

  logic [FRAC_W-1:0]         frac;
  logic [SIZE_W-1:0]         ix;
  logic [SIZE_W-1:0]         rest;
  logic [FRAC_W+6:0]         lo_prod;
  logic [SIZE_W+6:0]         hi_prod;
  logic                      snap_lo;
  logic                      snap_hi;
  logic [FRAC_W+SCALE_W-1:0] prod_nxt;
  side_t                     side_nxt;

  assign frac    = in_rem[FRAC_W-1:0];
  assign ix      = in_quot[SIZE_W-1:0];
  assign rest    = cfg.dst - in_rem;
  assign lo_prod = (FRAC_W+7)'(frac) * (FRAC_W+7)'(100);
  assign hi_prod = (SIZE_W+7)'(rest) * (SIZE_W+7)'(100);
  assign snap_lo = lo_prod < (FRAC_W+7)'(cfg.src);
  assign snap_hi = hi_prod < (SIZE_W+7)'(cfg.src);
  assign prod_nxt = (FRAC_W+SCALE_W)'(frac) * (FRAC_W+SCALE_W)'(cfg.ws);

  always_comb begin
    side_nxt        = in_side;
    side_nxt.zero_w = snap_lo || snap_hi;
    side_nxt.ix     = (!snap_lo && snap_hi) ? ix + SIZE_W'(1) : ix;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= DVD_W'(prod_nxt);
      side_r <= side_nxt;
    end
  end

  assign out_valid = vld_r;
  assign out_prod  = prod_r;
  assign out_side  = side_r;

endmodule

`default_nettype wire

### design/brz_final.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brz_final
// Pins the right edge, scales the pixel index by the channel count and holds
// the result item in the output register.
// ----------------------------------------------------------------------------
module brz_final (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire logic [brz_pkg::DVD_W-1:0]    in_quot,
  input  wire brz_pkg::side_t               in_side,
  input  wire brz_pkg::cfg_t                cfg,
  output logic                              out_valid,
  output logic      [brz_pkg::OFFSET_W-1:0] out_offset,
  output logic      [brz_pkg::WEIGHT_W-1:0] out_weight,
  output logic                              out_error
);
  import brz_pkg::*;

  logic                     vld_r;
  logic [OFFSET_W-1:0]      offset_r;
  logic [WEIGHT_W-1:0]      weight_r;
  logic                     error_r;

  logic                     at_edge;
  logic [SIZE_W-1:0]        pix;
  logic [SIZE_W+CHAN_W-1:0] off_full;
  logic [OFFSET_W-1:0]      offset_nxt;
  logic [WEIGHT_W-1:0]      weight_nxt;

  assign at_edge  = in_side.ix >= cfg.src - SIZE_W'(1);
  assign pix      = at_edge ? cfg.src - SIZE_W'(2) : in_side.ix;
  assign off_full = (SIZE_W+CHAN_W)'(pix) * (SIZE_W+CHAN_W)'(cfg.cn);

  always_comb begin
    if (in_side.err) begin
      offset_nxt = '0;
      weight_nxt = '0;
    end else begin
      offset_nxt = off_full[OFFSET_W-1:0];
      if (at_edge) begin
        weight_nxt = WEIGHT_W'(cfg.ws);
      end else if (in_side.zero_w) begin
        weight_nxt = '0;
      end else begin
        weight_nxt = in_quot[WEIGHT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      offset_r <= offset_nxt;
      weight_r <= weight_nxt;
      error_r  <= in_side.err;
    end
  end

  assign out_valid  = vld_r;
  assign out_offset = offset_r;
  assign out_weight = weight_r;
  assign out_error  = error_r;

endmodule

`default_nettype wire

### design/bilinear_resize_fixed_weight_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bilinear_resize_fixed_weight_table
// Bilinear resize coordinate generator along one axis: for each destination
// index, the left source offset and the fixed-point right-pixel weight.
// ----------------------------------------------------------------------------
// From an accepted item to its result, each item passes one stage of range
// check and multiply, two 29-stage divider pipelines (position and weight),
// one snapping stage and the output register.
// Throughput is one item per cycle; the whole pipeline holds while a result
// waits at the output. Synchronous reset empties the pipeline and loads the
// registers with src_size 2, dst_size 1, channels 1 and weight_scale 256.
module bilinear_resize_fixed_weight_table (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  brz_in_if.sink                          in_ch,
  brz_out_if.source                       out_ch,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [brz_pkg::ADDR_W-1:0] cfg_paddr,
  input  wire logic [brz_pkg::DATA_W-1:0] cfg_pwdata,
  output logic      [brz_pkg::DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import brz_pkg::*;

  cfg_t             cfg;
  logic             en;

  logic             p_valid;
  logic [DVD_W-1:0] p_pos;
  side_t            p_side;

  logic             d1_valid;
  logic [DVD_W-1:0] d1_quot;
  logic [REM_W-1:0] d1_rem;
  side_t            d1_side;

  logic             w_valid;
  logic [DVD_W-1:0] w_prod;
  side_t            w_side;

  logic             d2_valid;
  logic [DVD_W-1:0] d2_quot;
  logic [REM_W-1:0] d2_rem;
  side_t            d2_side;

  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  brz_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  brz_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .in_index  (in_ch.dst_index),
    .cfg       (cfg),
    .out_valid (p_valid),
    .out_pos   (p_pos),
    .out_side  (p_side)
  );

  brz_div u_div_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (p_valid),
    .in_dvd    (p_pos),
    .in_dvs    (cfg.dst),
    .in_side   (p_side),
    .out_valid (d1_valid),
    .out_quot  (d1_quot),
    .out_rem   (d1_rem),
    .out_side  (d1_side)
  );

  brz_wprep u_wprep (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (d1_valid),
    .in_quot   (d1_quot),
    .in_rem    (d1_rem),
    .in_side   (d1_side),
    .cfg       (cfg),
    .out_valid (w_valid),
    .out_prod  (w_prod),
    .out_side  (w_side)
  );

  brz_div u_div_wgt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (w_valid),
    .in_dvd    (w_prod),
    .in_dvs    (cfg.dst),
    .in_side   (w_side),
    .out_valid (d2_valid),
    .out_quot  (d2_quot),
    .out_rem   (d2_rem),
    .out_side  (d2_side)
  );

  brz_final u_final (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (d2_valid),
    .in_quot    (d2_quot),
    .in_side    (d2_side),
    .cfg        (cfg),
    .out_valid  (out_ch.valid),
    .out_offset (out_ch.src_offset),
    .out_weight (out_ch.weight),
    .out_error  (out_ch.index_error)
  );

endmodule

`default_nettype wire
